/* rtl/ali_pkg.sv */
// Package for the array list core: depth, derived widths, operation and
// status codes, and the command struct broadcast to the row of slot cells.
// No dependencies; every rtl file imports it.
package ali_pkg;

  // Built depth of the slot row.
  localparam int DEPTH = 16;
  // Widths derived from the depth.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Fixed field widths.
  localparam int WORD_W = 32;
  localparam int INDEX_W = 8;
  localparam int CAP_W = 5;
  localparam int FILL_W = 5;
  localparam int STATUS_W = 2;
  localparam int MODE_W = 3;
  // Width used when comparing count, index and capacity.
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes carried by the input word.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_POP_BACK   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_PUSH_MID   = 3'd4,
    MODE_POP_MID    = 3'd5,
    MODE_SET        = 3'd6,
    MODE_GET        = 3'd7
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // What every cell does with its slot.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  // Command broadcast to the cell row.
  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   pos;   // insert, remove or write position
    logic [CNT_W-1:0]   last;  // highest slot touched by a shift
    logic [WORD_W-1:0]  word;  // word inserted or written
  } cell_cmd_t;

endpackage

/* rtl/ali_cell.sv */
// One slot of the list: a 32-bit register that takes its lower neighbor on
// an insert, its upper neighbor or zero on a remove, or the broadcast word.
// Depends on ali_pkg.
module ali_cell
  import ali_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  slot_id,
  input  cell_cmd_t         cmd,
  input  logic [WORD_W-1:0] lower_word,
  input  logic [WORD_W-1:0] upper_word,
  output logic [WORD_W-1:0] word
);

  logic [CNT_W-1:0]  id;
  logic [WORD_W-1:0] word_next;

  assign id = CNT_W'(slot_id);

  // Pick this slot's next word from the broadcast command.
  always_comb begin
    word_next = word;
    case (cmd.op)
      CELL_INSERT: begin
        if (id == cmd.pos) begin
          word_next = cmd.word;
        end else if ((id > cmd.pos) && (id <= cmd.last)) begin
          word_next = lower_word;
        end
      end
      CELL_REMOVE: begin
        if ((id >= cmd.pos) && (id < cmd.last)) begin
          word_next = upper_word;
        end else if (id == cmd.last) begin
          word_next = '0;
        end
      end
      CELL_WRITE: begin
        if (id == cmd.pos) begin
          word_next = cmd.word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // The slot is cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else begin
      word <= word_next;
    end
  end

endmodule

/* rtl/array_list_insert_delete_core.sv */
// Top level of the array list core: input decode, fill count, capacity
// register, the row of ali_cell slots and the output register.
// Depends on ali_pkg and ali_cell.
//
//  channel   direction  tdata (low bit up)                      tuser
//  s_axis    in         value[31:0], index[39:32]               mode[2:0]
//  m_axis    out        read_value[31:0], status[33:32],        -
//                       fill_count[38:34], zero[39]
//  cfg       in         capacity[4:0] written when cfg_wr_en    -
//
// Every operation finishes in the cycle it is accepted: all slots shift in
// parallel, so one word is taken per cycle when not stalled and its result
// word appears on m_axis the next cycle. A get reads the row through one
// 16-way mux. Reset clears all slots, the fill count and the output valid
// flag, sets capacity to 16. A stalled result holds m_axis and s_axis_tready
// stays high only while the output register is empty or being drained.
module array_list_insert_delete_core
  import ali_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,  // value[31:0], index[39:32]
  input  logic [MODE_W-1:0]    s_axis_tuser,  // mode[2:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // read_value, status, fill_count
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data
);

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [WORD_W-1:0] slot_q [DEPTH];
  logic              accept;
  mode_t             mode;
  logic [WORD_W-1:0] in_value;
  logic [INDEX_W-1:0] in_index;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  idx_ext;
  cell_cmd_t         cmd_dec;
  cell_cmd_t         cmd;
  status_t           status;
  logic [WORD_W-1:0] rd_value;
  logic              out_valid;
  logic [39:0]       out_data;

  assign mode     = mode_t'(s_axis_tuser);
  assign in_value = s_axis_tdata[31:0];
  assign in_index = s_axis_tdata[39:32];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;

  // Effective capacity never exceeds the built depth.
  assign cap_ext = CMP_W'(capacity);
  assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign cnt_ext = CMP_W'(count);
  assign idx_ext = CMP_W'(in_index);

  // Decode the operation into a cell command, status and read word.
  always_comb begin
    cmd_dec.op   = CELL_HOLD;
    cmd_dec.pos  = '0;
    cmd_dec.last = '0;
    cmd_dec.word = in_value;
    status       = ST_OK;
    rd_value     = '0;
    count_next   = count;
    unique case (mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_PUSH_MID: begin
        if (cnt_ext < eff_cap) begin
          cmd_dec.op   = CELL_INSERT;
          cmd_dec.last = count;
          if (mode == MODE_PUSH_BACK) begin
            cmd_dec.pos = count;
          end else if (mode == MODE_PUSH_FRONT) begin
            cmd_dec.pos = '0;
          end else begin
            cmd_dec.pos = count >> 1;
          end
          count_next = count + CNT_W'(1);
        end else begin
          status = ST_FULL;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT, MODE_POP_MID: begin
        if (count != '0) begin
          cmd_dec.op   = CELL_REMOVE;
          cmd_dec.last = count - CNT_W'(1);
          if (mode == MODE_POP_BACK) begin
            cmd_dec.pos = count - CNT_W'(1);
          end else if (mode == MODE_POP_FRONT) begin
            cmd_dec.pos = '0;
          end else begin
            cmd_dec.pos = count >> 1;
          end
          count_next = count - CNT_W'(1);
        end else begin
          status = ST_EMPTY;
        end
      end
      MODE_SET: begin
        if (idx_ext < eff_cap) begin
          cmd_dec.op  = CELL_WRITE;
          cmd_dec.pos = CNT_W'(in_index);
        end else begin
          status = ST_BADIDX;
        end
      end
      MODE_GET: begin
        if (idx_ext < eff_cap) begin
          rd_value = slot_q[in_index[IDX_W-1:0]];
        end else begin
          rd_value = '1;
          status   = ST_BADIDX;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // The row only moves when a word is accepted.
  always_comb begin
    cmd = cmd_dec;
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  // Row of slot cells, each linked to its two neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;

    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = slot_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_upper
      assign upper_w = slot_q[g+1];
    end

    ali_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .slot_id    (IDX_W'(g)),
      .cmd        (cmd),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word       (slot_q[g])
    );
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register: loaded on accept, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {1'b0, FILL_W'(count_next), status, rd_value};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* rtl/ali_checker.sv */
// Port-level checks for the array list core, bound to the top level.
// Depends on ali_pkg and array_list_insert_delete_core.
module ali_checker
  import ali_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [39:0]          m_axis_tdata
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // An empty report always comes with a zero fill count.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] == ST_EMPTY) |-> m_axis_tdata[38:34] == '0)
    else $error("empty status with nonzero fill count");

  // A bad index returns all ones (get) or zero (set).
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] == ST_BADIDX)
    |-> (m_axis_tdata[31:0] == 32'hFFFF_FFFF) || (m_axis_tdata[31:0] == 32'h0))
    else $error("bad index with unexpected read value");

  // A word accepted in one cycle is shown as a result in the next.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind array_list_insert_delete_core ali_checker u_ali_checker (.*);

/* tb/array_list_insert_delete_core_test.sv */
// Self-checking testbench for the array list core: directed table, then random
// list traffic under several capacity settings and idle patterns.
// Depends on ali_pkg and array_list_insert_delete_core.
`timescale 1ns / 1ps

module array_list_insert_delete_core_test;
  import ali_pkg::*;

  // Fields of one result word.
  typedef struct packed {
    logic [31:0] read_value;
    status_t     status;
    logic [4:0]  fill_count;
  } list_result_t;

  // One row of the directed table; a capacity write carries the new value in word.
  typedef struct packed {
    bit           is_cfg;
    mode_t        op;
    logic [31:0]  word;
    logic [7:0]   idx;
    bit           has_want;
    list_result_t want;
  } list_row_t;

  localparam list_result_t NO_RESULT = '{32'h0, ST_OK, 5'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // value[31:0], index[39:32]
  logic [2:0]  s_axis_tuser = '0;   // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // read_value[31:0], status[33:32], fill_count[38:34]
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  // Typed expectation that travels with the word currently offered.
  bit           row_has_want = 1'b0;
  list_result_t row_want = NO_RESULT;

  // Shadow copy of the list and its capacity register.
  logic [31:0] list_slots [DEPTH];
  int unsigned list_count;
  logic [4:0]  list_cap;

  list_result_t pending_results [$];
  int errors = 0;
  int words_in = 0;
  int cap_writes = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  array_list_insert_delete_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 125 MHz clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Applies one operation to the shadow list and returns the result it causes.
  function automatic list_result_t apply_list_op(input mode_t op, input logic [31:0] word,
                                                 input logic [7:0] idx);
    list_result_t res;
    int unsigned  cap;
    int unsigned  pos;
    int unsigned  i;
    cap = (list_cap > DEPTH) ? DEPTH : list_cap;
    res = NO_RESULT;
    pos = 0;
    case (op)
      MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_PUSH_MID: begin
        if (list_count < cap) begin
          if (op == MODE_PUSH_BACK) pos = list_count;
          else if (op == MODE_PUSH_MID) pos = list_count / 2;
          for (i = list_count; i > pos; i--) list_slots[i] = list_slots[i-1];
          list_slots[pos] = word;
          list_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT, MODE_POP_MID: begin
        if (list_count > 0) begin
          if (op == MODE_POP_BACK) pos = list_count - 1;
          else if (op == MODE_POP_MID) pos = list_count / 2;
          for (i = pos; i + 1 < list_count; i++) list_slots[i] = list_slots[i+1];
          list_slots[list_count-1] = '0;
          list_count--;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      MODE_SET: begin
        if (idx < cap) list_slots[idx] = word;
        else res.status = ST_BADIDX;
      end
      default: begin
        if (idx < cap) begin
          res.read_value = list_slots[idx];
        end else begin
          res.read_value = 32'hFFFF_FFFF;
          res.status = ST_BADIDX;
        end
      end
    endcase
    res.fill_count = 5'(list_count);
    return res;
  endfunction

  // Watches both handshakes: checks each result word, then predicts the word
  // taken at the same edge.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t predicted;
    if (rst) begin
      foreach (list_slots[k]) list_slots[k] = '0;
      list_count = 0;
      list_cap = CAP_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_axis_tdata);
          errors++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          status_hits[m_axis_tdata[33:32]]++;
          if (m_axis_tdata[31:0] !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[33:32] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[33:32]);
            errors++;
          end
          if (m_axis_tdata[38:34] !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, m_axis_tdata[38:34]);
            errors++;
          end
          if (m_axis_tdata[39] !== 1'b0) begin
            $error("pad: expected 0, got %b", m_axis_tdata[39]);
            errors++;
          end
        end
      end
      if (cfg_wr_en) list_cap = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = apply_list_op(mode_t'(s_axis_tuser), s_axis_tdata[31:0],
                                  s_axis_tdata[39:32]);
        pending_results.insert(pending_results.size(), row_has_want ? row_want : predicted);
        words_in++;
      end
    end
  end

  // Offers one word after idling each cycle at the sender's idle rate, and waits
  // until it is taken.
  task automatic send_list_op(input mode_t op, input logic [31:0] word, input logic [7:0] idx,
                              input bit has_want, input list_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {idx, word};
    s_axis_tuser <= op;
    row_has_want <= has_want;
    row_want <= want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops sending until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes the capacity register once the core is idle.
  task automatic write_capacity(input logic [4:0] cap);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_writes++;
  endtask

  // Random list traffic; the push share drifts so the fill level swings
  // between empty and full.
  task automatic run_random_traffic(input int n_items);
    int          k;
    int          r;
    int          push_pct;
    mode_t       op;
    logic [31:0] word;
    logic [7:0]  idx;
    push_pct = 40;
    for (k = 0; k < n_items; k++) begin
      if (k % 32 == 0) push_pct = $urandom_range(15, 65);
      // Let everything drain once per phase.
      if (k == n_items / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        case ($urandom_range(0, 2))
          0: op = MODE_PUSH_BACK;
          1: op = MODE_PUSH_FRONT;
          default: op = MODE_PUSH_MID;
        endcase
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0: op = MODE_POP_BACK;
          1: op = MODE_POP_FRONT;
          default: op = MODE_POP_MID;
        endcase
      end else if (r < 90) begin
        op = MODE_SET;
      end else begin
        op = MODE_GET;
      end
      case ($urandom_range(0, 9))
        0: word = 32'h7FFF_FFFF;
        1: word = 32'h8000_0000;
        2: word = 32'hFFFF_FFFF;
        3: word = 32'h0;
        default: word = $urandom;
      endcase
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 17));
      send_list_op(op, word, idx, 1'b0, NO_RESULT);
    end
  endtask

  // Directed table: empty list, extremes, every operation, capacity lowered
  // below the fill count, zero capacity and capacity above the built depth.
  list_row_t directed_rows [0:27] = '{
    '{1'b0, MODE_GET,        32'h0,         8'd0,   1'b1, '{32'h0, ST_OK, 5'd0}},
    '{1'b0, MODE_POP_BACK,   32'h0,         8'd0,   1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{1'b0, MODE_POP_FRONT,  32'h0,         8'd0,   1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{1'b0, MODE_POP_MID,    32'h0,         8'd0,   1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{1'b0, MODE_GET,        32'h0,         8'd255, 1'b1, '{32'hFFFF_FFFF, ST_BADIDX, 5'd0}},
    '{1'b0, MODE_SET,        32'h1,         8'd16,  1'b1, '{32'h0, ST_BADIDX, 5'd0}},
    '{1'b0, MODE_PUSH_BACK,  32'h7FFF_FFFF, 8'd0,   1'b1, '{32'h0, ST_OK, 5'd1}},
    '{1'b0, MODE_PUSH_FRONT, 32'h8000_0000, 8'd0,   1'b1, '{32'h0, ST_OK, 5'd2}},
    '{1'b0, MODE_PUSH_MID,   32'hFFFF_FFFF, 8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_PUSH_BACK,  32'h0,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_PUSH_MID,   32'h1234_5678, 8'd0,   1'b0, NO_RESULT},
    // Write and read beyond the fill count.
    '{1'b0, MODE_SET,        32'hA5A5_A5A5, 8'd15,  1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd15,  1'b0, NO_RESULT},
    '{1'b0, MODE_POP_MID,    32'h0,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_POP_FRONT,  32'h0,         8'd0,   1'b0, NO_RESULT},
    // Capacity below the fill count: pushes full, high slots out of range.
    '{1'b1, MODE_PUSH_BACK,  32'd2,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_PUSH_BACK,  32'h1,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_PUSH_FRONT, 32'h2,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_SET,        32'h5A5A_5A5A, 8'd2,   1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd3,   1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd1,   1'b0, NO_RESULT},
    '{1'b0, MODE_POP_BACK,   32'h0,         8'd0,   1'b0, NO_RESULT},
    // Zero capacity.
    '{1'b1, MODE_PUSH_BACK,  32'd0,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_POP_MID,    32'h0,         8'd0,   1'b0, NO_RESULT},
    // Capacity above the built depth acts as the depth.
    '{1'b1, MODE_PUSH_BACK,  32'd31,        8'd0,   1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd15,  1'b0, NO_RESULT},
    '{1'b0, MODE_GET,        32'h0,         8'd16,  1'b0, NO_RESULT}
  };

  // Capacity used in each random phase.
  logic [4:0] phase_caps [0:8] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd12, 5'd3, 5'd16};

  // Main sequence.
  initial begin
    int p;
    tx_idle_pct = 8;
    rx_idle_pct = 84;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_capacity(directed_rows[r].word[4:0]);
      end else begin
        send_list_op(directed_rows[r].op, directed_rows[r].word, directed_rows[r].idx,
                     directed_rows[r].has_want, directed_rows[r].want);
      end
    end
    for (p = 0; p < 9; p++) begin
      if (p < 3) begin
        tx_idle_pct = 8;
        rx_idle_pct = 84;
      end else if (p < 6) begin
        tx_idle_pct = 84;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_capacity(phase_caps[p]);
      run_random_traffic(230);
    end
    drain_results();
    $display("Ran %0d list operations over %0d capacity writes.", words_in, cap_writes);
    $display("Results seen: ok %0d, full %0d, empty %0d, bad index %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ali_pkg.sv
rtl/ali_cell.sv
rtl/array_list_insert_delete_core.sv
rtl/ali_checker.sv
tb/array_list_insert_delete_core_test.sv
